@@ sv/mste_pkg.sv @@
`default_nettype none
package mste_pkg;

    localparam int MAX_DEVICES = 4;
    localparam int TAPS        = 20;
    localparam int SCALE_DIV   = 100;

    localparam int DEV_W  = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
    localparam int TAP_W  = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int CNT_W  = $clog2(TAPS + 2);
    localparam int SAMP_W = 18;
    localparam int COEF_W = 16;
    localparam int PROD_W = SAMP_W + COEF_W;
    localparam int ACC_W  = PROD_W + TAP_W;
    localparam int SUM_W  = ACC_W + DEV_W;
    localparam int EST_W  = 24;
    localparam int OFS_W  = 18;
    localparam int CFG_W  = 24;
    localparam int IDX_W  = 3;

    localparam logic [1:0] FUNC_LOAD   = 2'd0;
    localparam logic [1:0] FUNC_PRIME  = 2'd1;
    localparam logic [1:0] FUNC_TICK   = 2'd2;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    localparam logic [IDX_W-1:0] REG_NUM_DEVICES  = 3'd0;
    localparam logic [IDX_W-1:0] REG_TEMP_OFFSET  = 3'd1;
    localparam logic [IDX_W-1:0] REG_HIGH_LIMIT   = 3'd2;
    localparam logic [IDX_W-1:0] REG_LOW_LIMIT    = 3'd3;
    localparam logic [IDX_W-1:0] REG_ALERT_ENABLE = 3'd4;

    typedef struct packed {
        logic              wr_sample;
        logic              prime;
        logic              load;
        logic [TAP_W-1:0]  load_tap;
        logic [TAP_W-1:0]  slot;
        logic [TAP_W-1:0]  rd_idx;
        logic [TAP_W-1:0]  tap;
        logic              prod_en;
        logic              acc_clr;
        logic              acc_en;
    } lane_ctrl_t;

endpackage
`default_nettype wire

@@ sv/mste_lane.sv @@
`default_nettype none
module mste_lane
    import mste_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire lane_ctrl_t               ctrl,
    input  wire logic signed [SAMP_W-1:0] sample,
    input  wire logic signed [COEF_W-1:0] coef_value,
    output logic signed [ACC_W-1:0]       acc
);

    logic signed [SAMP_W-1:0] hist_reg [TAPS];
    logic signed [COEF_W-1:0] coef_reg [TAPS];
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < TAPS; i++) hist_reg[i] <= '0;
        end else if (ctrl.prime) begin
            for (int i = 0; i < TAPS; i++) hist_reg[i] <= sample;
        end else if (ctrl.wr_sample) begin
            hist_reg[ctrl.slot] <= sample;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load) coef_reg[ctrl.load_tap] <= coef_value;
        if (ctrl.prod_en) prod_reg <= hist_reg[ctrl.rd_idx] * coef_reg[ctrl.tap];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
        end else if (ctrl.acc_clr) begin
            acc_reg <= '0;
        end else if (ctrl.acc_en) begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    assign acc = acc_reg;

endmodule
`default_nettype wire

@@ sv/mste_merge.sv @@
`default_nettype none
module mste_merge
    import mste_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     start,
    input  wire logic signed [ACC_W-1:0]  acc [MAX_DEVICES],
    input  wire logic signed [OFS_W-1:0]  temp_offset,
    input  wire logic signed [EST_W-1:0]  high_limit,
    input  wire logic signed [EST_W-1:0]  low_limit,
    input  wire logic                     alert_enable,
    output logic                          busy,
    output logic                          done,
    output logic signed [EST_W-1:0]       estimate,
    output logic                          alert
);

    localparam int EW = SUM_W + 2;
    localparam logic signed [EW-1:0] EMAX = EW'(8388607);
    localparam logic signed [EW-1:0] EMIN = -EW'(8388608);

    // The magnitude is split as hi * 2**LO_W + lo. Since 2**LO_W = SCALE_DIV * HI_Q + HI_R,
    // the quotient is hi * HI_Q plus the quotient of the small rest hi * HI_R + lo.
    localparam int     LO_W  = 20;
    localparam int     HI_W  = SUM_W - LO_W;
    localparam int     HI_Q  = (1 << LO_W) / SCALE_DIV;
    localparam int     HI_R  = (1 << LO_W) % SCALE_DIV;
    localparam int     QH_W  = HI_W + $clog2(HI_Q + 1);
    localparam int     R1_W  = HI_W + 7;
    // The rest stays below 2**R1_W, so a ceiling reciprocal with a shift of 34 is exact.
    localparam int     RC_SH = 34;
    localparam int     RC_W  = 2 * R1_W;
    localparam longint RECIP = ((longint'(1) << RC_SH) + SCALE_DIV - 1) / SCALE_DIV;

    typedef enum logic [1:0] {M_IDLE, M_SPLIT, M_MUL, M_FIN} mstate_t;

    mstate_t                 state_reg;
    logic [SUM_W-1:0]        mag_reg;
    logic                    neg_reg;
    logic [R1_W-1:0]         r1_reg;
    logic [QH_W-1:0]         qhi_reg;
    logic [SUM_W-1:0]        q_reg;
    logic                    done_reg;
    logic signed [EST_W-1:0] est_reg;
    logic                    alert_reg;

    logic signed [SUM_W-1:0] sum;
    logic [HI_W-1:0]         hi_part;
    logic [R1_W-1:0]         r1_next;
    logic [QH_W-1:0]         qhi_next;
    logic [RC_W-1:0]         rc_prod;
    logic [SUM_W-1:0]        q_next;
    logic signed [EW-1:0]    q_s;
    logic signed [EW-1:0]    est_full;
    logic signed [EST_W-1:0] est_sat;

    always_comb begin
        sum = '0;
        for (int i = 0; i < MAX_DEVICES; i++) sum = sum + SUM_W'(acc[i]);
    end

    always_comb begin
        hi_part  = mag_reg[SUM_W-1:LO_W];
        r1_next  = R1_W'(hi_part) * R1_W'(HI_R) + R1_W'(mag_reg[LO_W-1:0]);
        qhi_next = QH_W'(hi_part) * QH_W'(HI_Q);
        rc_prod  = RC_W'(r1_reg) * RC_W'(RECIP);
        q_next   = SUM_W'(qhi_reg) + SUM_W'(rc_prod[RC_W-1:RC_SH]);
    end

    always_comb begin
        q_s      = neg_reg ? -$signed({2'b00, q_reg}) : $signed({2'b00, q_reg});
        est_full = q_s + EW'(temp_offset);
        if (est_full > EMAX) est_sat = EST_W'(EMAX);
        else if (est_full < EMIN) est_sat = EST_W'(EMIN);
        else est_sat = EST_W'(est_full);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= M_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            case (state_reg)
                M_IDLE: begin
                    if (start) begin
                        neg_reg   <= sum[SUM_W-1];
                        mag_reg   <= sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
                        state_reg <= M_SPLIT;
                    end
                end
                M_SPLIT: begin
                    r1_reg    <= r1_next;
                    qhi_reg   <= qhi_next;
                    state_reg <= M_MUL;
                end
                M_MUL: begin
                    q_reg     <= q_next;
                    state_reg <= M_FIN;
                end
                M_FIN: begin
                    est_reg   <= est_sat;
                    alert_reg <= alert_enable &&
                                 (est_sat >= high_limit || est_sat <= low_limit);
                    done_reg  <= 1'b1;
                    state_reg <= M_IDLE;
                end
                default: state_reg <= M_IDLE;
            endcase
        end
    end

    assign busy     = (state_reg != M_IDLE);
    assign done     = done_reg;
    assign estimate = est_reg;
    assign alert    = alert_reg;

endmodule
`default_nettype wire

@@ sv/multi_sensor_fir_temp_estimator.sv @@
`default_nettype none
// Four-channel FIR temperature estimator. Load and prime requests give no
// result. A tick request stores the valid samples of the channels in use,
// then each lane in use runs one multiply-accumulate per tap, all lanes side
// by side; at the end of the MAC phase the merge unit latches the lane total.
// The merge unit then divides by 100 through reciprocal multiplication in its
// split and multiply states and applies offset, saturation and the alert
// compare in its final state; the result is then handed to the output
// register. A new request is taken as soon as the block is idle, even while
// a result still waits in the output register; a finished tick whose result
// finds that register full waits.
module multi_sensor_fir_temp_estimator
    import mste_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    // coeff_device[1:0], coeff_tap[6:2], coeff_value[22:7], sample_a[40:23],
    // sample_b[58:41], sample_c[76:59], sample_d[94:77], valid_mask[98:95]
    input  wire logic [103:0]      s_tdata,
    // func[1:0]
    input  wire logic [1:0]        s_tuser,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    // estimate[23:0], alert[24]
    output logic [31:0]            m_tdata,
    input  wire logic              cfg_wr_en,
    input  wire logic [IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_W-1:0]  cfg_data
);

    typedef enum logic [1:0] {ST_IDLE, ST_MAC, ST_DIV, ST_OUT} state_t;

    state_t                 state_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [TAP_W-1:0]       slot_reg;
    logic [2:0]             num_dev_reg;
    logic signed [OFS_W-1:0] offset_reg;
    logic signed [EST_W-1:0] high_reg;
    logic signed [EST_W-1:0] low_reg;
    logic                   alert_en_reg;
    logic                   m_valid_reg;
    logic [EST_W-1:0]       m_est_reg;
    logic                   m_alert_reg;

    logic [1:0]             func;
    logic [1:0]             coeff_device;
    logic [4:0]             coeff_tap;
    logic signed [COEF_W-1:0] coeff_value;
    logic signed [SAMP_W-1:0] samples [MAX_DEVICES];
    logic [3:0]             valid_mask;
    logic                   accept;
    logic [2:0]             nd;
    logic [MAX_DEVICES-1:0] in_use;
    logic                   prime_ok;
    logic [TAP_W-1:0]       tap;
    logic [TAP_W:0]         idx_wide;
    lane_ctrl_t             ctrl [MAX_DEVICES];
    logic signed [ACC_W-1:0] acc [MAX_DEVICES];
    logic                   merge_start;
    logic                   merge_busy;
    logic                   merge_done;
    logic signed [EST_W-1:0] merge_est;
    logic                   merge_alert;
    logic                   out_free;

    assign func         = s_tuser;
    assign coeff_device = s_tdata[1:0];
    assign coeff_tap    = s_tdata[6:2];
    assign coeff_value  = s_tdata[22:7];
    assign valid_mask   = s_tdata[98:95];
    always_comb begin
        samples[0] = s_tdata[40:23];
        samples[1] = s_tdata[58:41];
        samples[2] = s_tdata[76:59];
        samples[3] = s_tdata[94:77];
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign nd       = (num_dev_reg > 3'(MAX_DEVICES)) ? 3'(MAX_DEVICES) : num_dev_reg;
    assign tap      = cnt_reg[TAP_W-1:0];
    // Ring slot of tap j is slot - j, wrapped into the ring.
    assign idx_wide = (slot_reg >= tap) ? {1'b0, slot_reg} - {1'b0, tap}
                                        : {1'b0, slot_reg} + (TAP_W+1)'(TAPS) - {1'b0, tap};

    always_comb begin
        prime_ok = 1'b1;
        for (int i = 0; i < MAX_DEVICES; i++) begin
            in_use[i] = (3'(i) < nd);
            if (in_use[i] && !valid_mask[i]) prime_ok = 1'b0;
        end
    end

    always_comb begin
        for (int i = 0; i < MAX_DEVICES; i++) begin
            ctrl[i].wr_sample = accept && func == FUNC_TICK && in_use[i] && valid_mask[i];
            ctrl[i].prime     = accept && func == FUNC_PRIME && prime_ok && in_use[i];
            ctrl[i].load      = accept && func == FUNC_LOAD && coeff_device == 2'(i) &&
                                {1'b0, coeff_tap} < 6'(TAPS);
            ctrl[i].load_tap  = TAP_W'(coeff_tap);
            ctrl[i].slot      = slot_reg;
            ctrl[i].rd_idx    = idx_wide[TAP_W-1:0];
            ctrl[i].tap       = tap;
            ctrl[i].prod_en   = (state_reg == ST_MAC) && cnt_reg < CNT_W'(TAPS);
            ctrl[i].acc_clr   = accept && func == FUNC_TICK;
            // The product of tap j is added in the cycle after it is formed.
            ctrl[i].acc_en    = (state_reg == ST_MAC) && cnt_reg != '0 &&
                                cnt_reg <= CNT_W'(TAPS) && in_use[i];
        end
    end

    generate
        for (genvar g = 0; g < MAX_DEVICES; g++) begin : g_lane
            mste_lane u_lane (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ctrl       (ctrl[g]),
                .sample     (samples[g]),
                .coef_value (coeff_value),
                .acc        (acc[g])
            );
        end
    endgenerate

    assign merge_start = (state_reg == ST_MAC) && cnt_reg == CNT_W'(TAPS + 1);

    mste_merge u_merge (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .start        (merge_start),
        .acc          (acc),
        .temp_offset  (offset_reg),
        .high_limit   (high_reg),
        .low_limit    (low_reg),
        .alert_enable (alert_en_reg),
        .busy         (merge_busy),
        .done         (merge_done),
        .estimate     (merge_est),
        .alert        (merge_alert)
    );

    assign out_free = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_dev_reg  <= 3'd1;
            offset_reg   <= '0;
            high_reg     <= '0;
            low_reg      <= '0;
            alert_en_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_NUM_DEVICES:  num_dev_reg  <= cfg_data[2:0];
                REG_TEMP_OFFSET:  offset_reg   <= cfg_data[OFS_W-1:0];
                REG_HIGH_LIMIT:   high_reg     <= cfg_data[EST_W-1:0];
                REG_LOW_LIMIT:    low_reg      <= cfg_data[EST_W-1:0];
                REG_ALERT_ENABLE: alert_en_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            slot_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (state_reg == ST_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept && func == FUNC_TICK) begin
                        cnt_reg   <= '0;
                        state_reg <= ST_MAC;
                    end
                end
                ST_MAC: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (merge_start) begin
                        slot_reg  <= (slot_reg == TAP_W'(TAPS - 1)) ? '0 : slot_reg + 1'b1;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (merge_done) state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_free) begin
                        m_est_reg   <= merge_est;
                        m_alert_reg <= merge_alert;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, m_alert_reg, m_est_reg};

    // The divider must never be running while a new request can enter.
    a_idle_merge: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !merge_busy) else $error("merge busy while idle");

    a_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        merge_done |-> state_reg == ST_DIV) else $error("merge done out of sequence");

    a_slot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        slot_reg < TAP_W'(TAPS)) else $error("write slot out of range");

    a_out_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && out_free) |=> m_tvalid) else $error("result lost");

endmodule
`default_nettype wire

@@ bench/tb_multi_sensor_fir_temp_estimator.sv @@
`default_nettype none
module tb_multi_sensor_fir_temp_estimator;
    import mste_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int SETTLE      = 120;

    typedef struct {
        logic [1:0]         func;
        logic [1:0]         dev;
        logic [4:0]         tap;
        logic signed [15:0] coef;
        logic signed [17:0] samp [4];
        logic [3:0]         mask;
    } request_t;

    typedef struct packed {
        logic [23:0] estimate;
        logic        alert;
    } estimate_t;

    logic              aclk;
    logic              aresetn;
    logic              s_tvalid;
    logic              s_tready;
    logic [103:0]      s_tdata;
    logic [1:0]        s_tuser;
    logic              m_tvalid;
    logic              m_tready;
    logic [31:0]       m_tdata;
    logic              cfg_wr_en;
    logic [IDX_W-1:0]  cfg_index;
    logic [CFG_W-1:0]  cfg_data;

    multi_sensor_fir_temp_estimator dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Shadow copy of the estimator state.
    longint    sample_ring [4][TAPS];
    longint    coef_bank   [4][TAPS];
    int        ring_slot;
    int        channel_reg;
    longint    offset_reg;
    longint    high_reg;
    longint    low_reg;
    bit        alert_en_reg;

    estimate_t pending_estimates [$];
    int        errors;
    int        cycles;
    int        send_idle;
    int        recv_stall;
    int        n_requests;
    int        n_ticks;
    int        n_results;
    int        n_alerts;
    int        n_saturated;
    int        coef_span;

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycles,
                     pending_estimates.size());
            $display("tb_multi_sensor_fir_temp_estimator: FAIL");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall);
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d (cycle %0d)", what, got, want, cycles);
        errors++;
    endtask

    always @(posedge aclk) begin
        estimate_t head;
        if (aresetn && m_tvalid && m_tready) begin
            n_results++;
            if (pending_estimates.size() == 0) begin
                report_mismatch("unexpected result", m_tdata[23:0], 0);
            end else begin
                head = pending_estimates.pop_front();
                if (m_tdata[23:0] !== head.estimate)
                    report_mismatch("estimate", $signed(m_tdata[23:0]), $signed(head.estimate));
                if (m_tdata[24] !== head.alert)
                    report_mismatch("alert", m_tdata[24], head.alert);
            end
        end
    end

    function automatic int channels_active();
        return (channel_reg > MAX_DEVICES) ? MAX_DEVICES : channel_reg;
    endfunction

    // Applies one accepted request to the shadow state and queues the result of a tick.
    function automatic void estimator_predict(input request_t r);
        int        nd;
        int        slot;
        longint    acc;
        longint    est;
        estimate_t res;
        nd = channels_active();
        case (r.func)
            FUNC_LOAD: begin
                if (r.tap < TAPS) coef_bank[r.dev][r.tap] = r.coef;
            end
            FUNC_PRIME: begin
                for (int i = 0; i < nd; i++)
                    if (!r.mask[i]) return;
                for (int i = 0; i < nd; i++)
                    for (int j = 0; j < TAPS; j++) sample_ring[i][j] = r.samp[i];
            end
            FUNC_TICK: begin
                slot = ring_slot;
                acc  = 0;
                for (int i = 0; i < nd; i++)
                    if (r.mask[i]) sample_ring[i][slot] = r.samp[i];
                for (int i = 0; i < nd; i++)
                    for (int j = 0; j < TAPS; j++)
                        acc += sample_ring[i][(slot + TAPS - j) % TAPS] * coef_bank[i][j];
                est = acc / SCALE_DIV + offset_reg;
                if (est > 8388607) begin
                    est = 8388607;
                    n_saturated++;
                end
                if (est < -8388608) begin
                    est = -8388608;
                    n_saturated++;
                end
                ring_slot    = (slot + 1) % TAPS;
                res.estimate = est[23:0];
                res.alert    = alert_en_reg && (est >= high_reg || est <= low_reg);
                if (res.alert) n_alerts++;
                n_ticks++;
                pending_estimates.push_back(res);
            end
            default: ;
        endcase
    endfunction

    task automatic send_request(input request_t r);
        while ($urandom_range(0, 99) < send_idle) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = r.func;
        s_tdata  = {5'b0, r.mask, r.samp[3], r.samp[2], r.samp[1], r.samp[0],
                    r.coef, r.tap, r.dev};
        do @(posedge aclk); while (!s_tready);
        estimator_predict(r);
        n_requests++;
        @(negedge aclk);
    endtask

    // Waits for every result, then long enough for a tick still in flight.
    task automatic drain();
        s_tvalid = 1'b0;
        while (pending_estimates.size() != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input longint value);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data  = value[23:0];
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        case (idx)
            REG_NUM_DEVICES:  channel_reg  = value & 7;
            REG_TEMP_OFFSET:  offset_reg   = longint'($signed(value[17:0]));
            REG_HIGH_LIMIT:   high_reg     = longint'($signed(value[23:0]));
            REG_LOW_LIMIT:    low_reg      = longint'($signed(value[23:0]));
            REG_ALERT_ENABLE: alert_en_reg = value & 1;
            default: ;
        endcase
    endtask

    task automatic configure(input int nd, input longint ofs, input longint hi,
                             input longint lo, input bit en);
        drain();
        write_reg(REG_NUM_DEVICES, nd);
        write_reg(REG_TEMP_OFFSET, ofs);
        write_reg(REG_HIGH_LIMIT, hi);
        write_reg(REG_LOW_LIMIT, lo);
        write_reg(REG_ALERT_ENABLE, en);
    endtask

    function automatic logic signed [17:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return -18'sd131072;
            1: return 18'sd131071;
            2: return 18'($signed($urandom_range(0, 400)) - 200);
            default: return 18'($urandom);
        endcase
    endfunction

    function automatic logic signed [15:0] pick_coef();
        case ($urandom_range(0, 9))
            0: return -16'sd32768;
            1: return 16'sd32767;
            default: return 16'($signed($urandom_range(0, 2 * coef_span)) - coef_span);
        endcase
    endfunction

    function automatic request_t make_request(input logic [1:0] func, input logic [3:0] mask);
        request_t r;
        r.func = func;
        r.dev  = 2'($urandom);
        r.tap  = 5'($urandom);
        r.coef = pick_coef();
        for (int i = 0; i < 4; i++) r.samp[i] = pick_sample();
        r.mask = mask;
        return r;
    endfunction

    task automatic load_all_coefs();
        request_t r;
        for (int d = 0; d < 4; d++)
            for (int t = 0; t < TAPS; t++) begin
                r     = make_request(FUNC_LOAD, 4'($urandom));
                r.dev = 2'(d);
                r.tap = 5'(t);
                send_request(r);
            end
    endtask

    task automatic test_directed();
        request_t r;
        coef_span = 32767;
        configure(4, 0, 8388607, -8388608, 1);
        load_all_coefs();
        // Every coefficient at its maximum and every sample at an extreme drives
        // the sum far past the 24-bit range, in both directions.
        for (int d = 0; d < 4; d++)
            for (int t = 0; t < TAPS; t++) begin
                r      = make_request(FUNC_LOAD, 4'hf);
                r.dev  = 2'(d);
                r.tap  = 5'(t);
                r.coef = 16'sd32767;
                send_request(r);
            end
        r = make_request(FUNC_PRIME, 4'hf);
        for (int i = 0; i < 4; i++) r.samp[i] = 18'sd131071;
        send_request(r);
        r = make_request(FUNC_TICK, 4'hf);
        for (int i = 0; i < 4; i++) r.samp[i] = 18'sd131071;
        send_request(r);
        r = make_request(FUNC_PRIME, 4'hf);
        for (int i = 0; i < 4; i++) r.samp[i] = -18'sd131072;
        send_request(r);
        r = make_request(FUNC_TICK, 4'hf);
        for (int i = 0; i < 4; i++) r.samp[i] = -18'sd131072;
        send_request(r);
        // A prime with one invalid channel in use is dropped whole.
        r = make_request(FUNC_PRIME, 4'b1011);
        send_request(r);
        send_request(make_request(FUNC_TICK, 4'b0000));
        // Loads with a tap past the end and the unused function code are ignored.
        r = make_request(FUNC_LOAD, 4'hf);
        r.tap = 5'd31;
        send_request(r);
        r.tap = 5'd20;
        send_request(r);
        send_request(make_request(FUNC_UNUSED, 4'hf));
        send_request(make_request(FUNC_TICK, 4'b0101));
        // No channel in use: the estimate is the offset alone.
        configure(0, -131072, 0, -8388608, 1);
        send_request(make_request(FUNC_PRIME, 4'h0));
        send_request(make_request(FUNC_TICK, 4'hf));
        configure(0, 131071, 8388607, 131071, 1);
        send_request(make_request(FUNC_TICK, 4'hf));
        // A channel count above the maximum behaves as the maximum.
        configure(7, 0, 0, 0, 0);
        send_request(make_request(FUNC_TICK, 4'hf));
        send_request(make_request(FUNC_TICK, 4'h3));
    endtask

    task automatic random_phase(input int count, input int idle, input int stall);
        request_t r;
        int       nd;
        longint   hi;
        send_idle  = idle;
        recv_stall = stall;
        nd = $urandom_range(0, 7);
        hi = $signed($urandom_range(0, 40000)) - 20000;
        coef_span = ($urandom_range(0, 3) == 0) ? 32767 : $urandom_range(1, 300);
        configure(nd, $signed($urandom_range(0, 262143)) - 131072, hi,
                  hi - $signed($urandom_range(0, 40000)), $urandom_range(0, 3) != 0);
        for (int k = 0; k < count; k++) begin
            case ($urandom_range(0, 19))
                0, 1: r = make_request(FUNC_PRIME,
                                       ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'hf);
                2, 3, 4, 5: r = make_request(FUNC_LOAD, 4'($urandom));
                6: r = make_request(FUNC_UNUSED, 4'($urandom));
                default: r = make_request(FUNC_TICK, 4'($urandom));
            endcase
            send_request(r);
            if (k == count / 2 && idle == 0) begin
                // Hold back until the block has delivered everything.
                s_tvalid = 1'b0;
                while (pending_estimates.size() != 0) @(negedge aclk);
            end
        end
    endtask

    task automatic test_random();
        random_phase(135, 0, 0);
        random_phase(135, 68, 0);
        random_phase(135, 0, 68);
        random_phase(135, 37, 37);
        random_phase(135, 0, 0);
        random_phase(135, 68, 68);
        random_phase(135, 37, 37);
    endtask

    initial begin
        errors = 0;
        n_requests = 0;
        n_ticks = 0;
        n_results = 0;
        n_alerts = 0;
        n_saturated = 0;
        send_idle = 0;
        recv_stall = 0;
        coef_span = 32767;
        ring_slot = 0;
        channel_reg = 1;
        offset_reg = 0;
        high_reg = 0;
        low_reg = 0;
        alert_en_reg = 0;
        for (int d = 0; d < 4; d++)
            for (int t = 0; t < TAPS; t++) begin
                sample_ring[d][t] = 0;
                coef_bank[d][t] = 0;
            end
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        m_tready  = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_directed();
        test_random();
        drain();

        $display("%0d requests sent, %0d ticks, %0d results checked", n_requests, n_ticks,
                 n_results);
        $display("%0d alerts and %0d saturated estimates over directed corners and seven random phases",
                 n_alerts, n_saturated);
        if (errors == 0) begin
            $display("tb_multi_sensor_fir_temp_estimator: PASS");
        end else begin
            $display("%0d mismatches", errors);
            $display("tb_multi_sensor_fir_temp_estimator: FAIL");
        end
        $finish;
    end

endmodule
`default_nettype wire

@@ filelist.f @@
sv/mste_pkg.sv
sv/mste_lane.sv
sv/mste_merge.sv
sv/multi_sensor_fir_temp_estimator.sv
bench/tb_multi_sensor_fir_temp_estimator.sv
